>>> rtl/rtqi_pkg.sv
package rtqi_pkg;

  // payload field widths
  localparam int FUNC_W    = 2;
  localparam int LEVEL_W   = 3;
  localparam int CHUNK_W   = 20;
  localparam int RATE_W    = 24;
  localparam int SCORE_W   = 15;
  localparam int PROD_W    = SCORE_W + RATE_W;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int LVL_CFG_W  = 4;
  localparam int CHK_CFG_W  = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS_IN_USE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT   = CFG_IDX_W'(1);

  localparam logic [LVL_CFG_W-1:0] LEVELS_RESET = LVL_CFG_W'(8);
  localparam logic [CHK_CFG_W-1:0] CHUNKS_RESET = CHK_CFG_W'(64);

  // largest score, 100.0 in Q7.8
  localparam logic [SCORE_W-1:0] SCORE_MAX = SCORE_W'(25600);

  // item function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LADDER = 2'd0,
    FUNC_SCORE  = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  // control sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_WR,
    ST_RD,
    ST_CHK,
    ST_MUL,
    ST_DST,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

>>> rtl/rtqi_in_if.sv
interface rtqi_in_if import rtqi_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [LEVEL_W-1:0]   level;
  logic [CHUNK_W-1:0]   chunk;
  logic [RATE_W-1:0]    rate_kbps;
  logic [RATE_W-1:0]    bitrate_value;
  logic [SCORE_W-1:0]   score_value;

  modport source (output valid, func, level, chunk, rate_kbps, bitrate_value, score_value,
                  input ready);
  modport sink (input valid, func, level, chunk, rate_kbps, bitrate_value, score_value,
                output ready);
endinterface

>>> rtl/rtqi_out_if.sv
interface rtqi_out_if import rtqi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               is_answer;
  logic [SCORE_W-1:0] quality;

  modport source (output valid, is_answer, quality, input ready);
  modport sink (input valid, is_answer, quality, output ready);
endinterface

>>> rtl/rtqi_cfg_if.sv
interface rtqi_cfg_if import rtqi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/rate_to_quality_interpolator.sv
// Rate-to-quality lookup with linear interpolation. The ladder memory holds
// up to LEVELS ascending bitrates and the score memory one Q7.8 score per
// level for each of up to CHUNKS chunk rows. One item is handled at a time.
// A ladder write or a no-op goes straight to the output state. A score write
// first reduces the chunk number modulo chunk_count in a serial divider
// (ST_MOD), then writes the score (ST_WR). A query does the same reduction,
// then reads and checks the ladder levels one at a time (ST_RD, ST_CHK), and
// when the rate falls between two points it multiplies (ST_MUL), starts the
// divider (ST_DST) and runs a serial divide (ST_DIV) before the output state.
// The next item is taken while the result waits in the output register.
// Configuration writes are taken in any cycle and complete at once.
module rate_to_quality_interpolator
  import rtqi_pkg::*;
#(
  parameter int LEVELS = 8,
  parameter int CHUNKS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  rtqi_in_if.sink     in_bus,
  rtqi_out_if.source  out_bus,
  rtqi_cfg_if.sink    cfg_bus
);

  localparam int IW  = $clog2(LEVELS);
  localparam int CDW = $clog2(CHUNKS + 1);
  localparam int AW  = $clog2(CHUNKS * LEVELS);

  state_t state_r, state_nxt;

  logic [LVL_CFG_W-1:0] levels_r;
  logic [CHK_CFG_W-1:0] chunks_r;

  logic [FUNC_W-1:0]  func_r;
  logic [LEVEL_W-1:0] lvl_r;
  logic [RATE_W-1:0]  rate_r;
  logic [SCORE_W-1:0] scv_r;
  logic [AW-1:0]      base_r;
  logic [IW-1:0]      idx_r;
  logic [RATE_W-1:0]  r0_r, r1_r;
  logic [SCORE_W-1:0] s0_r, s1_r;
  logic               neg_r;
  logic [PROD_W-1:0]  prod_r;
  logic               ans_r;
  logic [SCORE_W-1:0] res_r;

  logic               out_valid_r;
  logic               out_answer_r;
  logic [SCORE_W-1:0] out_quality_r;

  logic [RATE_W-1:0]  ladder_mem [LEVELS];
  logic [SCORE_W-1:0] score_mem [CHUNKS * LEVELS];
  logic [RATE_W-1:0]  ladder_q;
  logic [SCORE_W-1:0] score_q;

  logic               in_fire;
  logic               lvl_ok;
  logic [CDW-1:0]     eff_chunks;
  logic [IW-1:0]      last_idx;
  logic [SCORE_W-1:0] scv_clamp;
  logic [SCORE_W-1:0] mag;
  logic [RATE_W-1:0]  dr;
  logic [RATE_W-1:0]  db;
  logic               out_free;

  logic               mod_start, mod_done;
  logic [CHUNK_W-1:0] mod_quo;
  logic [CDW-1:0]     mod_rem;
  logic               div_start, div_done;
  logic [SCORE_W-1:0] div_quo;
  logic [RATE_W-1:0]  div_rem;

  // configuration registers
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= LEVELS_RESET;
      chunks_r <= CHUNKS_RESET;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        CFG_LEVELS_IN_USE: levels_r <= cfg_bus.data[LVL_CFG_W-1:0];
        CFG_CHUNK_COUNT:   chunks_r <= cfg_bus.data[CHK_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective register values after clamping
  always_comb begin
    if (chunks_r == '0) begin
      eff_chunks = CDW'(1);
    end else if (32'(chunks_r) > CHUNKS) begin
      eff_chunks = CDW'(CHUNKS);
    end else begin
      eff_chunks = CDW'(chunks_r);
    end
    if (levels_r == '0) begin
      last_idx = '0;
    end else if (32'(levels_r) > LEVELS) begin
      last_idx = IW'(LEVELS - 1);
    end else begin
      last_idx = IW'(levels_r - LVL_CFG_W'(1));
    end
  end

  assign in_bus.ready = (state_r == ST_IDLE);
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign lvl_ok       = 32'(in_bus.level) < LEVELS;
  assign scv_clamp    = (in_bus.score_value > SCORE_MAX) ? SCORE_MAX : in_bus.score_value;

  // chunk row reduction
  assign mod_start = in_fire &&
                     (in_bus.func == FUNC_SCORE || in_bus.func == FUNC_QUERY);

  rtqi_seqdiv #(
    .NW (CHUNK_W),
    .DW (CDW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .rem_init ('0),
    .num      (in_bus.chunk),
    .den      (eff_chunks),
    .done     (mod_done),
    .quo      (mod_quo),
    .rem      (mod_rem)
  );

  // interpolation divide; the quotient never exceeds the score span
  assign div_start = (state_r == ST_DST);
  assign db        = r1_r - r0_r;

  rtqi_seqdiv #(
    .NW (SCORE_W),
    .DW (RATE_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (prod_r[PROD_W-1:SCORE_W]),
    .num      (prod_r[SCORE_W-1:0]),
    .den      (db),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // ladder memory: written on transaction accept, read during scan
  always_ff @(posedge clk) begin
    if (in_fire && in_bus.func == FUNC_LADDER && lvl_ok) begin
      ladder_mem[IW'(in_bus.level)] <= in_bus.bitrate_value;
    end
    if (state_r == ST_RD) begin
      ladder_q <= ladder_mem[idx_r];
    end
  end

  // score memory
  always_ff @(posedge clk) begin
    if (state_r == ST_WR && 32'(lvl_r) < LEVELS) begin
      score_mem[base_r + AW'(lvl_r)] <= scv_r;
    end
    if (state_r == ST_RD) begin
      score_q <= score_mem[base_r + AW'(idx_r)];
    end
  end

  assign mag = neg_r ? (s0_r - s1_r) : (s1_r - s0_r);
  assign dr  = rate_r - r0_r;

  // item registers and scan datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_bus.func;
      lvl_r  <= in_bus.level;
      rate_r <= in_bus.rate_kbps;
      scv_r  <= scv_clamp;
      ans_r  <= 1'b0;
      res_r  <= '0;
    end
    unique case (state_r)
      ST_MOD: begin
        base_r <= AW'(mod_rem) * AW'(LEVELS);
        idx_r  <= '0;
        r0_r   <= '0;
        s0_r   <= '0;
      end
      ST_CHK: begin
        if (rate_r < ladder_q) begin
          r1_r  <= ladder_q;
          s1_r  <= score_q;
          neg_r <= score_q < s0_r;
        end else begin
          r0_r  <= ladder_q;
          s0_r  <= score_q;
          idx_r <= idx_r + IW'(1);
          if (idx_r == last_idx) begin
            ans_r <= 1'b1;
            res_r <= score_q;
          end
        end
      end
      ST_MUL: begin
        prod_r <= PROD_W'(mag) * PROD_W'(dr);
        if (r1_r <= r0_r) begin
          ans_r <= 1'b1;
          res_r <= s0_r;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          ans_r <= 1'b1;
          res_r <= neg_r ? (s0_r - div_quo) : (s0_r + div_quo);
        end
      end
      default: ;
    endcase
  end

  assign out_free = !out_valid_r || out_bus.ready;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = mod_start ? ST_MOD : ST_OUT;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_nxt = (func_r == FUNC_QUERY) ? ST_RD : ST_WR;
        end
      end
      ST_WR:  state_nxt = ST_OUT;
      ST_RD:  state_nxt = ST_CHK;
      ST_CHK: begin
        if (rate_r < ladder_q) begin
          state_nxt = ST_MUL;
        end else if (idx_r == last_idx) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_MUL: state_nxt = (r1_r <= r0_r) ? ST_OUT : ST_DST;
      ST_DST: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_answer_r  <= ans_r;
      out_quality_r <= res_r;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.is_answer = out_answer_r;
  assign out_bus.quality   = out_quality_r;

endmodule

>>> rtl/rtqi_seqdiv.sv
// restoring divider, one quotient bit per cycle
module rtqi_seqdiv #(
  parameter int NW = 20,
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] rem_init,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] num_r;
  logic [DW-1:0] rem_r;
  logic [DW:0]   trial;
  logic          fits;

  // one trial subtraction
  assign trial = {rem_r, num_r[NW-1]};
  assign fits  = trial >= {1'b0, den};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  // datapath: quotient bits shift in where dividend bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      num_r <= num;
    end else if (busy_r && cnt_r != '0) begin
      rem_r <= fits ? DW'(trial - {1'b0, den}) : DW'(trial);
      num_r <= {num_r[NW-2:0], fits};
    end
  end

  assign done = busy_r && (cnt_r == '0);
  assign quo  = num_r;
  assign rem  = rem_r;

endmodule
